// ----- rtl/core/lprf_pkg.sv -----
// ----------------------------------------------------------------------------
// lprf_pkg: shared types, constants and microcode for the prime run finder
// Control word layout, condition codes, sequencer step labels and the
// microprogram table that drives the datapath.
// ----------------------------------------------------------------------------
package lprf_pkg;

    localparam int MAX_ITEMS_DEF = 1024;

    localparam int VAL_W   = 16;  // input value, signed
    localparam int NUM_W   = 15;  // magnitude of a value that reaches trial division
    localparam int DIV_W   = 8;   // trial divisor, stays below 184
    localparam int SQ_W    = 16;  // divisor squared
    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int STEP_W  = 4;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_ACC,
        COND_SKIP,
        COND_LT2,
        COND_SQ_GT,
        COND_BUSY,
        COND_REM_ZERO,
        COND_NOT_LAST,
        COND_OUT_FULL
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT   = 4'd0;
    localparam step_t STEP_RANGE  = 4'd1;
    localparam step_t STEP_INIT   = 4'd2;
    localparam step_t STEP_SQUARE = 4'd3;
    localparam step_t STEP_BOUND  = 4'd4;
    localparam step_t STEP_DIVIDE = 4'd5;
    localparam step_t STEP_DWAIT  = 4'd6;
    localparam step_t STEP_TEST   = 4'd7;
    localparam step_t STEP_LOOP   = 4'd8;
    localparam step_t STEP_PRIME  = 4'd9;
    localparam step_t STEP_COMP   = 4'd10;
    localparam step_t STEP_FIN    = 4'd11;
    localparam step_t STEP_HOLD   = 4'd12;
    localparam step_t STEP_EMIT   = 4'd13;

    typedef struct packed {
        logic  in_ready;
        logic  load;
        logic  d_init;
        logic  sq_load;
        logic  d_inc;
        logic  rem_start;
        logic  run_prime;
        logic  run_clear;
        logic  pos_inc;
        logic  out_load;
        logic  seq_clear;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic acc;
        logic skip;
        logic lt2;
        logic sq_gt;
        logic busy;
        logic rem_zero;
        logic last;
        logic out_full;
    } flags_t;

    // Microprogram. A step whose condition holds jumps to target, else falls through.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        begin
            w        = '0;
            w.cond   = COND_NONE;
            w.target = STEP_WAIT;
            unique case (step)
                STEP_WAIT: begin
                    w.in_ready = 1'b1;
                    w.load     = 1'b1;
                    w.cond     = COND_NO_ACC;
                    w.target   = STEP_WAIT;
                end
                STEP_RANGE: begin
                    w.cond   = COND_SKIP;
                    w.target = STEP_FIN;
                end
                STEP_INIT: begin
                    w.d_init = 1'b1;
                    w.cond   = COND_LT2;
                    w.target = STEP_COMP;
                end
                STEP_SQUARE: begin
                    w.sq_load = 1'b1;
                end
                STEP_BOUND: begin
                    w.cond   = COND_SQ_GT;
                    w.target = STEP_PRIME;
                end
                STEP_DIVIDE: begin
                    w.rem_start = 1'b1;
                end
                STEP_DWAIT: begin
                    w.cond   = COND_BUSY;
                    w.target = STEP_DWAIT;
                end
                STEP_TEST: begin
                    w.d_inc  = 1'b1;
                    w.cond   = COND_REM_ZERO;
                    w.target = STEP_COMP;
                end
                STEP_LOOP: begin
                    w.cond   = COND_ALWAYS;
                    w.target = STEP_SQUARE;
                end
                STEP_PRIME: begin
                    w.run_prime = 1'b1;
                    w.pos_inc   = 1'b1;
                    w.cond      = COND_ALWAYS;
                    w.target    = STEP_FIN;
                end
                STEP_COMP: begin
                    w.run_clear = 1'b1;
                    w.pos_inc   = 1'b1;
                end
                STEP_FIN: begin
                    w.cond   = COND_NOT_LAST;
                    w.target = STEP_WAIT;
                end
                STEP_HOLD: begin
                    w.cond   = COND_OUT_FULL;
                    w.target = STEP_HOLD;
                end
                STEP_EMIT: begin
                    w.out_load  = 1'b1;
                    w.seq_clear = 1'b1;
                    w.cond      = COND_ALWAYS;
                    w.target    = STEP_WAIT;
                end
                default: begin
                    w.cond   = COND_ALWAYS;
                    w.target = STEP_WAIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// ----- rtl/core/lprf_rem.sv -----
// ----------------------------------------------------------------------------
// lprf_rem: iterative remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module lprf_rem (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lprf_pkg::NUM_W-1:0]   dividend,
    input  logic [lprf_pkg::DIV_W-1:0]   divisor,
    output logic                         busy,
    output logic [lprf_pkg::DIV_W-1:0]   rem
);

    localparam int NW = lprf_pkg::NUM_W;
    localparam int DW = lprf_pkg::DIV_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NW-2:0], 1'b0};
            // borrow out means the trial value is below the divisor: restore
            rem_next = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("remainder unit not busy after start");
`endif

endmodule

// ----- rtl/core/lprf_seq.sv -----
// ----------------------------------------------------------------------------
// lprf_seq: microcode sequencer
// Step counter, microprogram lookup and conditional jump selection.
// ----------------------------------------------------------------------------
module lprf_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  lprf_pkg::flags_t  flags,
    output lprf_pkg::ctrl_t   ctrl
);

    lprf_pkg::step_t step_reg, step_next;
    lprf_pkg::ctrl_t word;
    logic            taken;

    assign word = lprf_pkg::ucode(step_reg);

    always_comb begin
        unique case (word.cond)
            lprf_pkg::COND_NONE:     taken = 1'b0;
            lprf_pkg::COND_ALWAYS:   taken = 1'b1;
            lprf_pkg::COND_NO_ACC:   taken = !flags.acc;
            lprf_pkg::COND_SKIP:     taken = flags.skip;
            lprf_pkg::COND_LT2:      taken = flags.lt2;
            lprf_pkg::COND_SQ_GT:    taken = flags.sq_gt;
            lprf_pkg::COND_BUSY:     taken = flags.busy;
            lprf_pkg::COND_REM_ZERO: taken = flags.rem_zero;
            lprf_pkg::COND_NOT_LAST: taken = !flags.last;
            lprf_pkg::COND_OUT_FULL: taken = flags.out_full;
            default:                 taken = 1'b0;
        endcase
        step_next = taken ? word.target : step_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= lprf_pkg::STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    assign ctrl = word;

`ifndef NO_ASSERTIONS
    a_wait_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == lprf_pkg::STEP_WAIT && !flags.acc) |=> step_reg == lprf_pkg::STEP_WAIT)
        else $error("sequencer left wait step without a beat");
`endif

endmodule

// ----- rtl/core/lprf_dp.sv -----
// ----------------------------------------------------------------------------
// lprf_dp: trial division and run tracking datapath
// Holds the item under test, the trial divisor and its square, and the
// position and run counters; driven one control word per cycle.
// ----------------------------------------------------------------------------
module lprf_dp #(
    parameter int MAX_ITEMS = lprf_pkg::MAX_ITEMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lprf_pkg::ctrl_t               ctrl,
    input  logic                          accept,
    input  logic signed [lprf_pkg::VAL_W-1:0] value,
    input  logic                          last,
    output lprf_pkg::flags_t              flags,
    output logic [lprf_pkg::START_W-1:0]  run_start,
    output logic [lprf_pkg::LEN_W-1:0]    run_length
);

    localparam int PW = $clog2(MAX_ITEMS + 1);
    localparam int VW = lprf_pkg::VAL_W;
    localparam int NW = lprf_pkg::NUM_W;
    localparam int DW = lprf_pkg::DIV_W;
    localparam int QW = lprf_pkg::SQ_W;
    localparam int SW = lprf_pkg::START_W;
    localparam int LW = lprf_pkg::LEN_W;

    logic signed [VW-1:0] n_reg;
    logic                 last_reg;
    logic [DW-1:0]        d_reg;
    logic [QW-1:0]        sq_reg;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [PW-1:0]        cur_reg, cur_next;
    logic [PW-1:0]        best_reg, best_next;
    logic [PW-1:0]        bstart_reg, bstart_next;
    logic [PW-1:0]        cur_inc;
    logic                 rem_busy;
    logic [DW-1:0]        rem_val;

    lprf_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.rem_start),
        .dividend (n_reg[NW-1:0]),
        .divisor  (d_reg),
        .busy     (rem_busy),
        .rem      (rem_val)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.load && accept) begin
            n_reg    <= value;
            last_reg <= last;
        end
        if (ctrl.d_init) begin
            d_reg <= DW'(2);
        end else if (ctrl.d_inc) begin
            // 2, then odd divisors only
            d_reg <= (d_reg == DW'(2)) ? DW'(3) : d_reg + DW'(2);
        end
        if (ctrl.sq_load) begin
            sq_reg <= QW'(d_reg) * QW'(d_reg);
        end
    end

    assign cur_inc = cur_reg + 1'b1;

    always_comb begin
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        best_next   = best_reg;
        bstart_next = bstart_reg;
        if (ctrl.seq_clear) begin
            pos_next    = '0;
            cur_next    = '0;
            best_next   = '0;
            bstart_next = '0;
        end else begin
            if (ctrl.pos_inc) begin
                pos_next = pos_reg + 1'b1;
            end
            if (ctrl.run_clear) begin
                cur_next = '0;
            end
            if (ctrl.run_prime) begin
                cur_next = cur_inc;
                // strictly longer only, so the first of equal runs wins
                if (cur_inc > best_reg) begin
                    best_next   = cur_inc;
                    bstart_next = pos_reg - cur_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            cur_reg    <= '0;
            best_reg   <= '0;
            bstart_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            cur_reg    <= cur_next;
            best_reg   <= best_next;
            bstart_reg <= bstart_next;
        end
    end

    always_comb begin
        flags          = '0;
        flags.skip     = (pos_reg == PW'(MAX_ITEMS));
        flags.lt2      = (n_reg < VW'(2));
        flags.sq_gt    = (sq_reg > {1'b0, n_reg[NW-1:0]});
        flags.busy     = rem_busy;
        flags.rem_zero = (rem_val == '0);
        flags.last     = last_reg;
    end

    assign run_start  = SW'(bstart_reg);
    assign run_length = LW'(best_reg);

`ifndef NO_ASSERTIONS
    a_best_ge_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        best_reg >= cur_reg)
        else $error("current run longer than best run");

    a_best_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(bstart_reg) + 32'(best_reg)) <= 32'(pos_reg))
        else $error("best run reaches past the current position");
`endif

endmodule

// ----- rtl/core/longest_prime_run_finder_core.sv -----
// ----------------------------------------------------------------------------
// longest_prime_run_finder_core: longest run of primes in a framed stream
// Top level: stream ports, result register, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each input beat carries one signed 16-bit value; tlast closes the sequence.
// Every value among the first MAX_ITEMS of a sequence is tested for primality
// by trial division (2, then odd divisors up to the square root) on one shared
// remainder unit that retires one bit per cycle; later values are skipped and
// values below 2 count as not prime. Each trial divisor passes through square,
// bound compare, remainder start, the remainder iterations, test and loop.
// On the tlast beat one result beat follows with the start index and length
// of the longest prime run (the first of equal runs, zeros if there were
// none), after which the counters clear for the next sequence; the tlast
// beat waits while an earlier result has not been taken. The result sits in
// an output register, so a new input beat is taken while it waits.
// ----------------------------------------------------------------------------
module longest_prime_run_finder_core #(
    parameter int MAX_ITEMS = lprf_pkg::MAX_ITEMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [9:0] run_start, [20:10] run_length, [23:21] zero
);

    localparam int SW = lprf_pkg::START_W;
    localparam int LW = lprf_pkg::LEN_W;

    lprf_pkg::ctrl_t  ctrl;
    lprf_pkg::flags_t dp_flags;
    lprf_pkg::flags_t flags;
    logic             accept;
    logic [SW-1:0]    run_start;
    logic [LW-1:0]    run_length;
    logic             m_valid_reg, m_valid_next;
    logic [SW-1:0]    m_start_reg;
    logic [LW-1:0]    m_len_reg;

    assign s_tready = ctrl.in_ready;
    assign accept   = s_tvalid && ctrl.in_ready;

    lprf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    lprf_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .accept     (accept),
        .value      (s_tdata),
        .last       (s_tlast),
        .flags      (dp_flags),
        .run_start  (run_start),
        .run_length (run_length)
    );

    always_comb begin
        flags          = dp_flags;
        flags.acc      = accept;
        flags.out_full = m_valid_reg;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (ctrl.out_load) begin
            m_start_reg <= run_start;
            m_len_reg   <= run_length;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_len_reg, m_start_reg};

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> !m_valid_reg)
        else $error("result beat overwritten before it was taken");
`endif

endmodule
